/* rtl/core/lrmh_pkg.sv */
// ----------------------------------------------------------------------------
// lrmh_pkg
// Types and constants shared by the request priority queue.
// ----------------------------------------------------------------------------
package lrmh_pkg;

	localparam int CAPACITY = 256;
	localparam int CLK_W    = 32;
	localparam int PID_W    = 10;
	localparam int ENTRY_W  = CLK_W + PID_W;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OCC_W    = 9;
	localparam int STAT_W   = 2;

	// clock in the upper bits, so a plain compare is lexicographic order
	typedef logic [ENTRY_W-1:0] entry_t;
	typedef logic [CNT_W-1:0]   count_t;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE
	} op_t;

	typedef struct packed {
		op_t    op;
		entry_t entry;
	} cmd_t;

	// what one cell shows its neighbours
	typedef struct packed {
		entry_t entry;
		logic   valid;
		logic   take;
	} link_t;

endpackage

/* rtl/core/lrmh_if.sv */
// ----------------------------------------------------------------------------
// lrmh_if
// Request and response channels of the request priority queue.
// ----------------------------------------------------------------------------
interface lrmh_req_if;
	logic                      valid;
	logic                      ready;
	logic                      action;
	logic [lrmh_pkg::CLK_W-1:0] clock_value;
	logic [lrmh_pkg::PID_W-1:0] process_id;

	modport source (output valid, action, clock_value, process_id, input ready);
	modport sink   (input valid, action, clock_value, process_id, output ready);
endinterface

interface lrmh_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [lrmh_pkg::STAT_W-1:0] status;
	logic [lrmh_pkg::CLK_W-1:0]  removed_clock;
	logic [lrmh_pkg::PID_W-1:0]  removed_process;
	logic [lrmh_pkg::OCC_W-1:0]  occupancy;

	modport source (output valid, status, removed_clock, removed_process, occupancy,
		input ready);
	modport sink   (input valid, status, removed_clock, removed_process, occupancy,
		output ready);
endinterface

/* rtl/core/lamport_request_min_heap.sv */
// ----------------------------------------------------------------------------
// lamport_request_min_heap
// Priority queue of mutual-exclusion requests, minimum (clock, pid) first.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                           beat
//  req      in   action, clock_value, process_id                   one item
//  rsp      out  status, removed_clock, removed_process, occupancy one result
//
//  One request beat is taken per cycle while ready; its result is registered
//  and shows on rsp the next cycle. The figure is set by the row of cells: an
//  insert compares the new entry against every slot at once and the row shifts
//  right from the insertion point, a remove shifts the whole row left by one
//  slot. Reset clears the count, the slot valid bits and the result valid bit.
//  req is ready while the result register is empty or its beat is being taken.
// ----------------------------------------------------------------------------
module lamport_request_min_heap (
	input  logic       clk,
	input  logic       arst_n,
	lrmh_req_if.sink   req,
	lrmh_rsp_if.source rsp
);

	lrmh_pkg::cmd_t   cmd;
	lrmh_pkg::link_t  lnk [lrmh_pkg::CAPACITY];
	lrmh_pkg::link_t  edge_left;
	lrmh_pkg::link_t  edge_right;
	lrmh_pkg::count_t cnt_q;
	lrmh_pkg::count_t cnt_next;
	lrmh_pkg::status_t status_next;
	logic             accept;
	logic             full;
	logic             empty;

	logic                         rsp_valid_q;
	lrmh_pkg::status_t            status_q;
	lrmh_pkg::entry_t             removed_q;
	logic [lrmh_pkg::OCC_W-1:0]   occ_q;

	assign full   = (cnt_q == lrmh_pkg::CNT_W'(lrmh_pkg::CAPACITY));
	assign empty  = (cnt_q == '0);
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept = req.valid && req.ready;

	always_comb begin
		cmd.entry   = {req.clock_value, req.process_id};
		cmd.op      = lrmh_pkg::OP_NONE;
		cnt_next    = cnt_q;
		status_next = lrmh_pkg::STATUS_OK;
		if (accept) begin
			if (req.action == lrmh_pkg::ACT_INSERT) begin
				if (full) begin
					status_next = lrmh_pkg::STATUS_FULL;
				end else begin
					cmd.op   = lrmh_pkg::OP_INSERT;
					cnt_next = cnt_q + lrmh_pkg::CNT_W'(1);
				end
			end else begin
				if (empty) begin
					status_next = lrmh_pkg::STATUS_EMPTY;
				end else begin
					cmd.op   = lrmh_pkg::OP_REMOVE;
					cnt_next = cnt_q - lrmh_pkg::CNT_W'(1);
				end
			end
		end
	end

	// ends of the row: nothing shifts in from the left, empty slot on the right
	assign edge_left  = '{entry: '0, valid: 1'b1, take: 1'b0};
	assign edge_right = '{entry: '0, valid: 1'b0, take: 1'b0};

	for (genvar g = 0; g < lrmh_pkg::CAPACITY; g++) begin : g_cell
		lrmh_pkg::link_t l_in;
		lrmh_pkg::link_t r_in;
		if (g == 0) begin : g_first
			assign l_in = edge_left;
		end else begin : g_mid_l
			assign l_in = lnk[g-1];
		end
		if (g == lrmh_pkg::CAPACITY - 1) begin : g_last
			assign r_in = edge_right;
		end else begin : g_mid_r
			assign r_in = lnk[g+1];
		end
		lrmh_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (l_in),
			.right  (r_in),
			.self   (lnk[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_next;
			removed_q <= (cmd.op == lrmh_pkg::OP_REMOVE) ? lnk[0].entry : '0;
			occ_q     <= lrmh_pkg::OCC_W'(cnt_next);
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.removed_clock   = removed_q[lrmh_pkg::ENTRY_W-1:lrmh_pkg::PID_W];
	assign rsp.removed_process = removed_q[lrmh_pkg::PID_W-1:0];
	assign rsp.occupancy       = occ_q;

	// head slot is filled exactly when the count is non-zero
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		lnk[0].valid == !empty)
		else $error("head slot valid disagrees with count");

	// tail slot is filled exactly when the queue is full
	a_tail_valid: assert property (@(posedge clk) disable iff (!arst_n)
		lnk[lrmh_pkg::CAPACITY-1].valid == full)
		else $error("tail slot valid disagrees with count");

	// the two front slots stay in order
	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		lnk[1].valid |-> (lnk[0].entry <= lnk[1].entry))
		else $error("front of queue out of order");

	// a rejected insert reports a full queue and no entry
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == lrmh_pkg::STATUS_FULL) |->
		(occ_q == lrmh_pkg::OCC_W'(lrmh_pkg::CAPACITY) && removed_q == '0))
		else $error("full status with wrong occupancy or entry");

	// a remove that succeeds lowers the count by one
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lrmh_pkg::OP_REMOVE) |=> (cnt_q == $past(cnt_q) - lrmh_pkg::CNT_W'(1)))
		else $error("count not lowered after remove");

endmodule

/* rtl/core/lrmh_cell.sv */
// ----------------------------------------------------------------------------
// lrmh_cell
// One slot of the sorted queue: holds an entry, takes a new one or shifts.
// ----------------------------------------------------------------------------
module lrmh_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  lrmh_pkg::cmd_t   cmd,
	input  lrmh_pkg::link_t  left,
	input  lrmh_pkg::link_t  right,
	output lrmh_pkg::link_t  self
);

	lrmh_pkg::entry_t entry_q;
	logic             valid_q;
	logic             take;

	// an empty slot counts as larger than anything; equal entries stay ahead
	assign take = !valid_q || (cmd.entry < entry_q);

	assign self.entry = entry_q;
	assign self.valid = valid_q;
	assign self.take  = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				lrmh_pkg::OP_INSERT: begin
					if (take) begin
						valid_q <= left.take ? left.valid : 1'b1;
					end
				end
				lrmh_pkg::OP_REMOVE: begin
					valid_q <= right.valid;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			lrmh_pkg::OP_INSERT: begin
				if (take) begin
					entry_q <= left.take ? left.entry : cmd.entry;
				end
			end
			lrmh_pkg::OP_REMOVE: begin
				entry_q <= right.entry;
			end
			default: begin
			end
		endcase
	end

endmodule

/* test/lamport_request_min_heap_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lamport_request_min_heap_test
// Drives request beats into the queue and checks every response beat against
// a shadow heap kept in the bench or a reply typed into the table. A short
// table of hand-picked requests comes first, then random mixes and a fill to
// capacity and past it, under three patterns of idling on both channels.
// ----------------------------------------------------------------------------
module lamport_request_min_heap_test;

	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;
	localparam int REPORT_MAX  = 10;

	typedef struct {
		lrmh_pkg::status_t          status;
		logic [lrmh_pkg::CLK_W-1:0] clock;
		logic [lrmh_pkg::PID_W-1:0] pid;
		logic [lrmh_pkg::OCC_W-1:0] occupancy;
	} reply_t;

	typedef struct {
		logic                       action;
		logic [lrmh_pkg::CLK_W-1:0] clock;
		logic [lrmh_pkg::PID_W-1:0] pid;
		bit                         fixed;   // reply typed in below
		reply_t                     reply;
	} step_t;

	logic clk;
	logic arst_n;

	lrmh_req_if req ();
	lrmh_rsp_if rsp ();

	lamport_request_min_heap uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow heap, slots 1..CAPACITY
	lrmh_pkg::entry_t shadow_heap [1:lrmh_pkg::CAPACITY];
	int               shadow_count;

	reply_t awaited_replies [$];
	step_t  request_table [$];
	int     mismatches;
	int     send_idle_pct;
	int     recv_idle_pct;
	bit     hold_go;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#2_000_000;
		$display("lamport_request_min_heap regression: fail");
		$finish;
	end

	task automatic swap_shadow(input int a, input int b);
		lrmh_pkg::entry_t t;
		t = shadow_heap[a];
		shadow_heap[a] = shadow_heap[b];
		shadow_heap[b] = t;
	endtask

	task automatic apply_request(input logic act, input logic [lrmh_pkg::CLK_W-1:0] cv,
		input logic [lrmh_pkg::PID_W-1:0] pid, output reply_t r);
		int node;
		int pick;
		lrmh_pkg::entry_t root;
		r.status = lrmh_pkg::STATUS_OK;
		r.clock  = '0;
		r.pid    = '0;
		if (act == lrmh_pkg::ACT_INSERT) begin
			if (shadow_count >= lrmh_pkg::CAPACITY) begin
				r.status = lrmh_pkg::STATUS_FULL;
			end else begin
				shadow_count++;
				shadow_heap[shadow_count] = {cv, pid};
				node = shadow_count;
				while (node > 1) begin
					if (shadow_heap[node / 2] <= shadow_heap[node]) break;
					swap_shadow(node / 2, node);
					node = node / 2;
				end
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = lrmh_pkg::STATUS_EMPTY;
			end else begin
				root = shadow_heap[1];
				r.clock = root[lrmh_pkg::ENTRY_W-1:lrmh_pkg::PID_W];
				r.pid   = root[lrmh_pkg::PID_W-1:0];
				shadow_heap[1] = shadow_heap[shadow_count];
				shadow_count--;
				node = 1;
				while (2 * node <= shadow_count) begin
					pick = 2 * node;
					if (pick + 1 <= shadow_count &&
							shadow_heap[pick + 1] < shadow_heap[pick])
						pick = pick + 1;
					if (shadow_heap[pick] >= shadow_heap[node]) break;
					swap_shadow(pick, node);
					node = pick;
				end
			end
		end
		r.occupancy = shadow_count[lrmh_pkg::OCC_W-1:0];
	endtask

	// one request beat; returns at the falling edge after acceptance
	task automatic send_request(input logic act, input logic [lrmh_pkg::CLK_W-1:0] cv,
		input logic [lrmh_pkg::PID_W-1:0] pid, input bit fixed, input reply_t typed);
		reply_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid       <= 1'b1;
		req.action      <= act;
		req.clock_value <= cv;
		req.process_id  <= pid;
		do @(posedge clk); while (!(req.valid && req.ready));
		apply_request(act, cv, pid, r);
		awaited_replies.push_back(fixed ? typed : r);
		@(negedge clk);
	endtask

	function automatic logic [lrmh_pkg::CLK_W-1:0] pick_clock();
		case ($urandom_range(3))
			0:       return lrmh_pkg::CLK_W'($urandom_range(7));
			1:       return {lrmh_pkg::CLK_W{1'b1}} - lrmh_pkg::CLK_W'($urandom_range(3));
			default: return lrmh_pkg::CLK_W'($urandom);
		endcase
	endfunction

	function automatic logic [lrmh_pkg::PID_W-1:0] pick_pid();
		case ($urandom_range(2))
			0:       return lrmh_pkg::PID_W'($urandom_range(3));
			default: return lrmh_pkg::PID_W'($urandom);
		endcase
	endfunction

	task automatic send_random(input int insert_pct);
		reply_t none;
		none = '{lrmh_pkg::STATUS_OK, '0, '0, '0};
		send_request(($urandom_range(99) < insert_pct) ? lrmh_pkg::ACT_INSERT :
			lrmh_pkg::ACT_REMOVE, pick_clock(), pick_pid(), 1'b0, none);
	endtask

	// sender drops valid and waits for every outstanding response
	task automatic await_replies();
		req.valid <= 1'b0;
		do @(negedge clk); while (awaited_replies.size() != 0);
	endtask

	function automatic step_t row(input logic act, input logic [lrmh_pkg::CLK_W-1:0] cv,
		input logic [lrmh_pkg::PID_W-1:0] pid, input bit fixed, input lrmh_pkg::status_t st,
		input logic [lrmh_pkg::CLK_W-1:0] rc, input logic [lrmh_pkg::PID_W-1:0] rp,
		input logic [lrmh_pkg::OCC_W-1:0] occ);
		step_t s;
		s.action = act;
		s.clock  = cv;
		s.pid    = pid;
		s.fixed  = fixed;
		s.reply  = '{st, rc, rp, occ};
		return s;
	endfunction

	// response side: random stalls, and a long hold-off when asked
	initial begin
		int held;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				rsp.ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
			end
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		reply_t w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited_replies.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("unexpected response beat: status %0d clock %h pid %h occ %0d",
						rsp.status, rsp.removed_clock, rsp.removed_process, rsp.occupancy);
				mismatches++;
			end else begin
				w = awaited_replies.pop_front();
				if (rsp.status !== w.status || rsp.removed_clock !== w.clock ||
						rsp.removed_process !== w.pid || rsp.occupancy !== w.occupancy) begin
					if (mismatches < REPORT_MAX)
						$display({"mismatch: expected status %0d clock %h pid %h occ %0d,",
							" got status %0d clock %h pid %h occ %0d"},
							w.status, w.clock, w.pid, w.occupancy, rsp.status,
							rsp.removed_clock, rsp.removed_process, rsp.occupancy);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int i;
		int waited;
		step_t s;
		reply_t none;
		none            = '{lrmh_pkg::STATUS_OK, '0, '0, '0};
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.action      = lrmh_pkg::ACT_INSERT;
		req.clock_value = '0;
		req.process_id  = '0;
		shadow_count    = 0;
		mismatches      = 0;
		hold_go         = 1'b0;
		send_idle_pct   = 28;
		recv_idle_pct   = 64;

		// extremes, order at the root, tie-break on pid, duplicates, empty
		request_table.push_back(row(lrmh_pkg::ACT_REMOVE, '0, '0, 1'b1,
			lrmh_pkg::STATUS_EMPTY, '0, '0, 9'd0));
		request_table.push_back(row(lrmh_pkg::ACT_INSERT, '1, '1, 1'b1,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd1));
		request_table.push_back(row(lrmh_pkg::ACT_INSERT, '0, '0, 1'b1,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd2));
		request_table.push_back(row(lrmh_pkg::ACT_REMOVE, '0, '0, 1'b1,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd1));
		request_table.push_back(row(lrmh_pkg::ACT_REMOVE, '0, '0, 1'b1,
			lrmh_pkg::STATUS_OK, '1, '1, 9'd0));
		request_table.push_back(row(lrmh_pkg::ACT_REMOVE, '0, '0, 1'b1,
			lrmh_pkg::STATUS_EMPTY, '0, '0, 9'd0));
		request_table.push_back(row(lrmh_pkg::ACT_INSERT, 32'd100, 10'd5, 1'b0,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd0));
		request_table.push_back(row(lrmh_pkg::ACT_INSERT, 32'd100, 10'd3, 1'b0,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd0));
		request_table.push_back(row(lrmh_pkg::ACT_INSERT, 32'd100, 10'd3, 1'b0,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd0));
		request_table.push_back(row(lrmh_pkg::ACT_INSERT, 32'd99, '1, 1'b0,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd0));
		request_table.push_back(row(lrmh_pkg::ACT_INSERT, 32'd101, '0, 1'b0,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd0));
		request_table.push_back(row(lrmh_pkg::ACT_INSERT, '0, '1, 1'b0,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd0));
		request_table.push_back(row(lrmh_pkg::ACT_INSERT, 32'hAAAAAAAA, 10'h155, 1'b0,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd0));
		request_table.push_back(row(lrmh_pkg::ACT_INSERT, 32'h55555555, 10'h2AA, 1'b0,
			lrmh_pkg::STATUS_OK, '0, '0, 9'd0));
		for (i = 0; i < 9; i++)
			request_table.push_back(row(lrmh_pkg::ACT_REMOVE, '0, '0, 1'b0,
				lrmh_pkg::STATUS_OK, '0, '0, 9'd0));

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// sender idles lightly, receiver heavily
		foreach (request_table[k]) begin
			s = request_table[k];
			send_request(s.action, s.clock, s.pid, s.fixed, s.reply);
		end
		for (i = 0; i < 30; i++) begin
			if (i == 10) hold_go = 1'b1;
			send_random(60);
		end
		await_replies();

		// other way round: fill to capacity, then past full
		send_idle_pct = 64;
		recv_idle_pct = 28;
		while (shadow_count < lrmh_pkg::CAPACITY)
			send_request(lrmh_pkg::ACT_INSERT, pick_clock(), pick_pid(), 1'b0, none);
		for (i = 0; i < 3; i++)
			send_request(lrmh_pkg::ACT_INSERT, pick_clock(), pick_pid(), 1'b0, none);
		hold_go = 1'b1;
		for (i = 0; i < 6; i++) send_random(50);
		await_replies();

		// no idling
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (i = 0; i < 110; i++) begin
			if (i == 50) hold_go = 1'b1;
			send_random(30);
		end
		req.valid <= 1'b0;

		waited = 0;
		while (awaited_replies.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (awaited_replies.size() != 0) begin
			$display("%0d response beats never arrived", awaited_replies.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("lamport_request_min_heap regression: pass");
		else
			$display("lamport_request_min_heap regression: fail");
		$finish;
	end

endmodule
